### hw/rtl/ptcd_pkg.sv
// ============================================================================
// ptcd_pkg
// Shared constants, state codes and the status type of the pulse timing
// call decoder.
// ============================================================================
package ptcd_pkg;

    // field widths
    localparam int PERIOD_BITS = 24;
    localparam int COUNT_BITS  = 8;
    localparam int LATCH_BITS  = 19;
    localparam int AVG_BITS    = 32;
    localparam int FLAT_BITS   = 8;
    localparam int STATE_BITS  = 3;

    // divider retires two quotient bits per cycle
    localparam int DIV_RADIX_BITS = 2;
    localparam int DIV_STEPS      = AVG_BITS / DIV_RADIX_BITS;
    localparam int DIV_CNT_BITS   = $clog2(DIV_STEPS);

    // decoder state codes
    localparam logic [STATE_BITS-1:0] ST_IDLE        = 3'd0;
    localparam logic [STATE_BITS-1:0] ST_RESET_START = 3'd1;
    localparam logic [STATE_BITS-1:0] ST_RESET_END   = 3'd2;
    localparam logic [STATE_BITS-1:0] ST_FLAT_START  = 3'd3;
    localparam logic [STATE_BITS-1:0] ST_FLAT_END    = 3'd4;
    localparam logic [STATE_BITS-1:0] ST_RING_START  = 3'd5;
    localparam logic [STATE_BITS-1:0] ST_RING        = 3'd6;

    // timing windows in timer ticks (exclusive bounds)
    localparam logic [PERIOD_BITS-1:0] RST_PULSE_LO  = PERIOD_BITS'(200000);
    localparam logic [PERIOD_BITS-1:0] RST_PULSE_HI  = PERIOD_BITS'(500000);
    localparam logic [PERIOD_BITS-1:0] RST_GAP_LO    = PERIOD_BITS'(180000);
    localparam logic [PERIOD_BITS-1:0] RST_GAP_HI    = PERIOD_BITS'(250000);
    localparam logic [PERIOD_BITS-1:0] FLAT_LOW_LO   = PERIOD_BITS'(5);
    localparam logic [PERIOD_BITS-1:0] FLAT_LOW_HI   = PERIOD_BITS'(30);
    localparam logic [PERIOD_BITS-1:0] FLAT_HIGH_LO  = PERIOD_BITS'(150);
    localparam logic [PERIOD_BITS-1:0] FLAT_HIGH_HI  = PERIOD_BITS'(300);
    localparam logic [PERIOD_BITS-1:0] END_GAP_LO    = PERIOD_BITS'(30000);
    localparam logic [PERIOD_BITS-1:0] END_GAP_HI    = PERIOD_BITS'(1000000);
    localparam logic [PERIOD_BITS-1:0] RING_RESTART  = PERIOD_BITS'(8000000);
    localparam logic [PERIOD_BITS-1:0] RING_EDGE_MIN = PERIOD_BITS'(50000);

    // decoder registers as seen by the sequencer
    typedef struct packed {
        logic [STATE_BITS-1:0] state;
        logic [COUNT_BITS-1:0] count;
        logic [LATCH_BITS-1:0] reset_latch;
        logic [LATCH_BITS-1:0] end_latch;
        logic [AVG_BITS-1:0]   low_sum;
        logic [AVG_BITS-1:0]   high_sum;
        logic                  announce;
        logic [FLAT_BITS-1:0]  announced;
    } ptcd_status_t;

endpackage

### hw/rtl/ptcd_divider.sv
// ============================================================================
// ptcd_divider
// Shared iterative unsigned divider: 32-bit dividend by a count-wide
// divisor, two quotient bits per cycle.
// ============================================================================
module ptcd_divider (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic [ptcd_pkg::AVG_BITS-1:0]   dividend,
    input  logic [ptcd_pkg::COUNT_BITS-1:0] divisor,
    output logic                            done,
    output logic [ptcd_pkg::AVG_BITS-1:0]   quotient
);
    import ptcd_pkg::*;

    logic                    busy_reg, busy_next;
    logic                    done_reg, done_next;
    logic [DIV_CNT_BITS-1:0] cnt_reg, cnt_next;
    logic [AVG_BITS-1:0]     quo_reg, quo_next;
    logic [COUNT_BITS-1:0]   rem_reg, rem_next;
    logic [COUNT_BITS-1:0]   dvs_reg;
    logic [AVG_BITS-1:0]     step_quo;
    logic [COUNT_BITS-1:0]   step_rem;

    // two restoring shift-subtract steps on the narrow remainder
    always_comb
    begin
        logic [COUNT_BITS:0] wide;
        step_quo = quo_reg;
        step_rem = rem_reg;
        for (int i = 0; i < DIV_RADIX_BITS; i++)
        begin
            wide     = {step_rem, step_quo[AVG_BITS-1]};
            step_quo = {step_quo[AVG_BITS-2:0], 1'b0};
            if (wide >= {1'b0, dvs_reg})
            begin
                wide        = wide - {1'b0, dvs_reg};
                step_quo[0] = 1'b1;
            end
            step_rem = wide[COUNT_BITS-1:0];
        end
    end

    // iteration control
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = DIV_CNT_BITS'(DIV_STEPS - 1);
            quo_next  = dividend;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            quo_next = step_quo;
            rem_next = step_rem;
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        if (start)
        begin
            dvs_reg <= divisor;
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

`ifndef ASSERT_OFF
    // a started division is in progress on the next cycle
    assert property (@(posedge clk) disable iff (!rst_n) start |=> busy_reg)
        else $error("divider did not start");
    // completion only comes out of an iteration that was running
    assert property (@(posedge clk) disable iff (!rst_n) done_reg |-> $past(busy_reg))
        else $error("divider done without a running division");
`endif

endmodule

### hw/rtl/ptcd_decoder.sv
// ============================================================================
// ptcd_decoder
// Seven-state call decoder with its flat counter, period latches and
// pulse width sums, plus the announce enable register.
// ============================================================================
module ptcd_decoder (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic                             cfg_data,
    input  logic                             step,
    input  logic                             rising,
    input  logic [ptcd_pkg::PERIOD_BITS-1:0] period,
    output ptcd_pkg::ptcd_status_t           status
);
    import ptcd_pkg::*;

    logic         enable_reg;
    ptcd_status_t stat_reg, stat_next;

    // next decoder state for one edge
    always_comb
    begin
        stat_next           = stat_reg;
        stat_next.announce  = 1'b0;
        stat_next.announced = '0;
        unique case (stat_reg.state)
            ST_RESET_START:
            begin
                if (rising && period > RST_PULSE_LO && period < RST_PULSE_HI)
                begin
                    stat_next.reset_latch = period[LATCH_BITS-1:0];
                    stat_next.low_sum     = '0;
                    stat_next.high_sum    = '0;
                    stat_next.count       = '0;
                    stat_next.state       = ST_RESET_END;
                end
                else
                begin
                    stat_next.state = ST_IDLE;
                end
            end
            ST_RESET_END:
            begin
                if (!rising && period > RST_GAP_LO && period < RST_GAP_HI)
                begin
                    stat_next.state = ST_FLAT_START;
                end
                else
                begin
                    stat_next.state = ST_IDLE;
                end
            end
            ST_FLAT_START:
            begin
                if (rising && period > FLAT_LOW_LO && period < FLAT_LOW_HI)
                begin
                    stat_next.low_sum = stat_reg.low_sum + AVG_BITS'(period);
                    stat_next.count   = stat_reg.count + 1'b1;
                    stat_next.state   = ST_FLAT_END;
                end
                else
                begin
                    stat_next.state = ST_IDLE;
                end
            end
            ST_FLAT_END:
            begin
                priority if (!rising && period > FLAT_HIGH_LO && period < FLAT_HIGH_HI)
                begin
                    stat_next.high_sum = stat_reg.high_sum + AVG_BITS'(period);
                    stat_next.state    = ST_FLAT_START;
                end
                else if (!rising && period > END_GAP_LO && period < END_GAP_HI)
                begin
                    if (enable_reg)
                    begin
                        stat_next.announce  = 1'b1;
                        stat_next.announced = FLAT_BITS'(stat_reg.count);
                    end
                    stat_next.state = ST_RING_START;
                end
                else
                begin
                    stat_next.state = ST_IDLE;
                end
            end
            ST_RING_START:
            begin
                if (rising && period > RST_PULSE_LO && period < RST_PULSE_HI)
                begin
                    stat_next.end_latch = period[LATCH_BITS-1:0];
                    stat_next.state     = ST_IDLE;
                end
                else
                begin
                    stat_next.state = ST_RING;
                end
            end
            ST_RING:
            begin
                priority if (!rising && period > RING_RESTART)
                begin
                    stat_next.state = ST_RESET_START;
                end
                else if (period > RING_EDGE_MIN)
                begin
                    stat_next.state = rising ? ST_IDLE : ST_RING_START;
                end
                else
                begin
                    stat_next.state = ST_RING;
                end
            end
            // idle, and the unused code
            default:
            begin
                stat_next.state = rising ? ST_IDLE : ST_RESET_START;
            end
        endcase
    end

    // decoder and configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg <= 1'b0;
            stat_reg   <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                enable_reg <= cfg_data;
            end
            if (step)
            begin
                stat_reg <= stat_next;
            end
        end
    end

    assign status = stat_reg;

`ifndef ASSERT_OFF
    // an announcement only accompanies the move to ring start
    assert property (@(posedge clk) disable iff (!rst_n)
        stat_reg.announce |-> stat_reg.state == ST_RING_START)
        else $error("flat announcement outside ring start");
`endif

endmodule

### hw/rtl/pulse_timing_call_decoder_unit.sv
// ============================================================================
// pulse_timing_call_decoder_unit
// Top level: edge decoder, average sequencer around the shared divider,
// and the result register.
// ============================================================================
// Usage
//   input channel  : in_valid / in_ready, one line edge (rising, period)
//   result channel : out_valid / out_ready, one result per edge
//   config channel : cfg_valid / cfg_ready (always ready), cfg_data is the
//                    announce enable bit; write it only while the block idles
// Sequence
//   the decoder updates on the accepting edge, then the sequencer runs two
//   passes of the shared divider (low average, then high average), each with
//   a start state and a wait state, then a load state that waits while a
//   pending result has not been taken; in_ready is low from acceptance until
//   the load, so no new edge is taken before the last one's result is loaded
// Reset
//   rst_n clears the decoder to idle, the counter, latches and sums to zero
//   and the announce enable to off; no result is pending after reset
// Back-pressure
//   a finished result waits in the output register; the block takes the
//   next edge meanwhile and only holds the following result back until the
//   pending one has been taken
// ============================================================================
module pulse_timing_call_decoder_unit (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic                             cfg_data,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic                             rising,
    input  logic [ptcd_pkg::PERIOD_BITS-1:0] period,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic                             flat_valid,
    output logic [ptcd_pkg::FLAT_BITS-1:0]   flat_number,
    output logic [ptcd_pkg::STATE_BITS-1:0]  state_code,
    output logic [ptcd_pkg::LATCH_BITS-1:0]  last_reset_period,
    output logic [ptcd_pkg::LATCH_BITS-1:0]  last_end_period,
    output logic [ptcd_pkg::AVG_BITS-1:0]    low_average,
    output logic [ptcd_pkg::AVG_BITS-1:0]    high_average
);
    import ptcd_pkg::*;

    // sequencer codes
    localparam logic [2:0] SEQ_IDLE    = 3'd0;
    localparam logic [2:0] SEQ_LO_GO   = 3'd1;
    localparam logic [2:0] SEQ_LO_WAIT = 3'd2;
    localparam logic [2:0] SEQ_HI_GO   = 3'd3;
    localparam logic [2:0] SEQ_HI_WAIT = 3'd4;
    localparam logic [2:0] SEQ_LOAD    = 3'd5;

    logic [2:0]            seq_reg, seq_next;
    ptcd_status_t          status;
    logic                  in_accept;
    logic                  div_start;
    logic                  div_done;
    logic [AVG_BITS-1:0]   div_dividend;
    logic [COUNT_BITS-1:0] div_divisor;
    logic [AVG_BITS-1:0]   div_quotient;
    logic [AVG_BITS-1:0]   lo_quo_reg;
    logic                  out_free;
    logic                  load;
    logic                  out_valid_reg, out_valid_next;
    logic                  flat_valid_reg;
    logic [FLAT_BITS-1:0]  flat_number_reg;
    logic [STATE_BITS-1:0] state_code_reg;
    logic [LATCH_BITS-1:0] rst_pulse_reg;
    logic [LATCH_BITS-1:0] end_pulse_reg;
    logic [AVG_BITS-1:0]   low_avg_reg;
    logic [AVG_BITS-1:0]   high_avg_reg;

    assign cfg_ready = 1'b1;
    assign in_ready  = (seq_reg == SEQ_IDLE);
    assign in_accept = in_valid && in_ready;

    ptcd_decoder u_decoder (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_valid),
        .cfg_data (cfg_data),
        .step     (in_accept),
        .rising   (rising),
        .period   (period),
        .status   (status)
    );

    // divider operands: low sum by count, then high sum by count minus one
    assign div_start    = (seq_reg == SEQ_LO_GO) || (seq_reg == SEQ_HI_GO);
    assign div_dividend = (seq_reg == SEQ_LO_GO) ? status.low_sum : status.high_sum;
    assign div_divisor  = (seq_reg == SEQ_LO_GO) ? status.count
                                                 : status.count - 1'b1;

    ptcd_divider u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quotient)
    );

    // result register may be loaded when empty or being emptied
    assign out_free = !out_valid_reg || out_ready;
    assign load     = (seq_reg == SEQ_LOAD) && out_free;

    // sequencer
    always_comb
    begin
        seq_next = seq_reg;
        unique case (seq_reg)
            SEQ_IDLE:
            begin
                if (in_accept)
                begin
                    seq_next = SEQ_LO_GO;
                end
            end
            SEQ_LO_GO:
            begin
                seq_next = SEQ_LO_WAIT;
            end
            SEQ_LO_WAIT:
            begin
                if (div_done)
                begin
                    seq_next = SEQ_HI_GO;
                end
            end
            SEQ_HI_GO:
            begin
                seq_next = SEQ_HI_WAIT;
            end
            SEQ_HI_WAIT:
            begin
                if (div_done)
                begin
                    seq_next = SEQ_LOAD;
                end
            end
            SEQ_LOAD:
            begin
                if (out_free)
                begin
                    seq_next = SEQ_IDLE;
                end
            end
            default:
            begin
                seq_next = SEQ_IDLE;
            end
        endcase
    end

    // output valid
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_reg       <= SEQ_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            seq_reg       <= seq_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // low quotient and result payload
    always_ff @(posedge clk)
    begin
        if (seq_reg == SEQ_LO_WAIT && div_done)
        begin
            lo_quo_reg <= div_quotient;
        end
        if (load)
        begin
            flat_valid_reg  <= status.announce;
            flat_number_reg <= status.announced;
            state_code_reg  <= status.state;
            rst_pulse_reg   <= status.reset_latch;
            end_pulse_reg   <= status.end_latch;
            low_avg_reg     <= (status.count == '0) ? status.low_sum : lo_quo_reg;
            high_avg_reg    <= (status.count < COUNT_BITS'(2)) ? '0 : div_quotient;
        end
    end

    assign out_valid         = out_valid_reg;
    assign flat_valid        = flat_valid_reg;
    assign flat_number       = flat_number_reg;
    assign state_code        = state_code_reg;
    assign last_reset_period = rst_pulse_reg;
    assign last_end_period   = end_pulse_reg;
    assign low_average       = low_avg_reg;
    assign high_average      = high_avg_reg;

`ifndef ASSERT_OFF
    // an accepted edge closes the input until its result is built
    assert property (@(posedge clk) disable iff (!rst_n) in_accept |=> !in_ready)
        else $error("input reopened straight after a transaction");
    // divider completions only arrive while the sequencer waits for them
    assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (seq_reg == SEQ_LO_WAIT || seq_reg == SEQ_HI_WAIT))
        else $error("divider completion outside a wait state");
`endif

endmodule

### bench/tb.sv
`timescale 1ns / 1ps
// ============================================================================
// tb
// Self-checking bench for the pulse timing call decoder. Line edges go in
// over the input handshake; a bit-accurate decoder model predicts every
// result, which is checked field by field as it leaves the block. Directed
// window and ring cases come first, then a long flat run that wraps the
// counter, then randomised calls with noise, random pacing on both sides
// and the announce enable switched between phases.
// ============================================================================
module tb;

    import ptcd_pkg::*;

    typedef struct packed {
        logic                  flat_valid;
        logic [FLAT_BITS-1:0]  flat_number;
        logic [STATE_BITS-1:0] state_code;
        logic [LATCH_BITS-1:0] rst_pulse;
        logic [LATCH_BITS-1:0] end_pulse;
        logic [AVG_BITS-1:0]   low_avg;
        logic [AVG_BITS-1:0]   high_avg;
    } call_result_t;

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic                   cfg_data  = 1'b0;
    logic                   in_valid  = 1'b0;
    logic                   in_ready;
    logic                   rising    = 1'b0;
    logic [PERIOD_BITS-1:0] period    = '0;
    logic                   out_valid;
    logic                   out_ready = 1'b0;
    logic                   flat_valid;
    logic [FLAT_BITS-1:0]   flat_number;
    logic [STATE_BITS-1:0]  state_code;
    logic [LATCH_BITS-1:0]  last_reset_period;
    logic [LATCH_BITS-1:0]  last_end_period;
    logic [AVG_BITS-1:0]    low_average;
    logic [AVG_BITS-1:0]    high_average;

    // decoder model state
    logic [STATE_BITS-1:0] dec_state   = ST_IDLE;
    logic [COUNT_BITS-1:0] flat_cnt    = '0;
    logic [LATCH_BITS-1:0] reset_latch = '0;
    logic [LATCH_BITS-1:0] end_latch   = '0;
    logic [AVG_BITS-1:0]   low_sum     = '0;
    logic [AVG_BITS-1:0]   high_sum    = '0;
    logic                  announce_on = 1'b0;

    call_result_t pending_results[$];

    int err_cnt       = 0;
    int edges_sent    = 0;
    int calls_sent    = 0;
    int results_seen  = 0;
    int announce_seen = 0;
    int spoil_at      = -1;
    int call_pos      = 0;
    bit pace_on       = 1'b1;

    pulse_timing_call_decoder_unit uut (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_data          (cfg_data),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .rising            (rising),
        .period            (period),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .flat_valid        (flat_valid),
        .flat_number       (flat_number),
        .state_code        (state_code),
        .last_reset_period (last_reset_period),
        .last_end_period   (last_end_period),
        .low_average       (low_average),
        .high_average      (high_average)
    );

    // clock
    always #5 clk = ~clk;

    // overall time limit
    initial
    begin
        #10_000_000;
        $display("TB_ERROR");
        $finish;
    end

    // exclusive window test
    function automatic bit in_window(input logic [PERIOD_BITS-1:0] p,
                                     input logic [PERIOD_BITS-1:0] lo,
                                     input logic [PERIOD_BITS-1:0] hi);
        return (p > lo) && (p < hi);
    endfunction

    // advance the decoder model by one edge and queue the result it gives
    function automatic void decode_edge(input logic r, input logic [PERIOD_BITS-1:0] p);
        call_result_t res;
        logic [AVG_BITS-1:0] cnt_wide;
        res = '0;
        case (dec_state)
            ST_RESET_START:
            begin
                if (r && in_window(p, RST_PULSE_LO, RST_PULSE_HI))
                begin
                    reset_latch = p[LATCH_BITS-1:0];
                    low_sum     = '0;
                    high_sum    = '0;
                    flat_cnt    = '0;
                    dec_state   = ST_RESET_END;
                end
                else
                    dec_state = ST_IDLE;
            end
            ST_RESET_END:
            begin
                dec_state = (!r && in_window(p, RST_GAP_LO, RST_GAP_HI)) ?
                            ST_FLAT_START : ST_IDLE;
            end
            ST_FLAT_START:
            begin
                if (r && in_window(p, FLAT_LOW_LO, FLAT_LOW_HI))
                begin
                    low_sum   = low_sum + AVG_BITS'(p);
                    flat_cnt  = flat_cnt + 1'b1;
                    dec_state = ST_FLAT_END;
                end
                else
                    dec_state = ST_IDLE;
            end
            ST_FLAT_END:
            begin
                if (!r && in_window(p, FLAT_HIGH_LO, FLAT_HIGH_HI))
                begin
                    high_sum  = high_sum + AVG_BITS'(p);
                    dec_state = ST_FLAT_START;
                end
                else if (!r && in_window(p, END_GAP_LO, END_GAP_HI))
                begin
                    if (announce_on)
                    begin
                        res.flat_valid  = 1'b1;
                        res.flat_number = FLAT_BITS'(flat_cnt);
                    end
                    dec_state = ST_RING_START;
                end
                else
                    dec_state = ST_IDLE;
            end
            ST_RING_START:
            begin
                if (r && in_window(p, RST_PULSE_LO, RST_PULSE_HI))
                begin
                    end_latch = p[LATCH_BITS-1:0];
                    dec_state = ST_IDLE;
                end
                else
                    dec_state = ST_RING;
            end
            ST_RING:
            begin
                // edges that reach no threshold leave the state alone
                if (!r)
                begin
                    if (p > RING_RESTART)
                        dec_state = ST_RESET_START;
                    else if (p > RING_EDGE_MIN)
                        dec_state = ST_RING_START;
                end
                else if (p > RING_EDGE_MIN)
                    dec_state = ST_IDLE;
            end
            default:
                dec_state = r ? ST_IDLE : ST_RESET_START;
        endcase
        cnt_wide       = AVG_BITS'(flat_cnt);
        res.state_code = dec_state;
        res.rst_pulse  = reset_latch;
        res.end_pulse  = end_latch;
        res.low_avg    = (flat_cnt != 0) ? low_sum / cnt_wide : low_sum;
        res.high_avg   = (flat_cnt >= 2) ? high_sum / (cnt_wide - 1) : '0;
        pending_results.push_back(res);
    endfunction

    // one field compare
    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            err_cnt++;
        end
    endfunction

    // result checker
    always @(posedge clk)
    begin : result_check
        call_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result transaction with nothing expected, state_code %0d", state_code);
                err_cnt++;
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("flat_valid", 32'(want.flat_valid), 32'(flat_valid));
                check_field("flat_number", 32'(want.flat_number), 32'(flat_number));
                check_field("state_code", 32'(want.state_code), 32'(state_code));
                check_field("last_reset_period", 32'(want.rst_pulse),
                            32'(last_reset_period));
                check_field("last_end_period", 32'(want.end_pulse), 32'(last_end_period));
                check_field("low_average", want.low_avg, low_average);
                check_field("high_average", want.high_avg, high_average);
            end
            results_seen++;
            if (flat_valid === 1'b1)
                announce_seen++;
        end
    end

    // result side pacing: hold ready low for a random stall once a result shows
    initial
    begin
        int stall;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (pace_on)
            begin
                out_ready <= 1'b0;
                do
                    @(posedge clk);
                while (!out_valid);
                stall = $urandom_range(0, 14);
                repeat (stall) @(posedge clk);
            end
            if (out_ready !== 1'b1)
                out_ready <= 1'b1;
            do
                @(posedge clk);
            while (!(out_valid && out_ready));
        end
    end

    // send one edge transaction after a random gap
    task automatic send_edge(input logic r, input logic [PERIOD_BITS-1:0] p);
        int gap;
        gap = pace_on ? $urandom_range(0, 14) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        rising   <= r;
        period   <= p;
        do
            @(posedge clk);
        while (!in_ready);
        decode_edge(r, p);
        edges_sent++;
    endtask

    // stop sending and wait for every outstanding result
    task automatic wait_results_done();
        if (in_valid)
            in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    // announce enable write
    task automatic write_announce(input logic en);
        cfg_valid <= 1'b1;
        cfg_data  <= en;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid   <= 1'b0;
        announce_on = en;
    endtask

    function automatic logic [PERIOD_BITS-1:0] pick_in(input logic [PERIOD_BITS-1:0] lo,
                                                       input logic [PERIOD_BITS-1:0] hi);
        return PERIOD_BITS'($urandom_range(int'(lo) + 1, int'(hi) - 1));
    endfunction

    function automatic logic [PERIOD_BITS-1:0] pick_noise();
        case ($urandom_range(0, 3))
            0: return PERIOD_BITS'($urandom());
            1: return PERIOD_BITS'($urandom_range(0, 400));
            2: return PERIOD_BITS'($urandom_range(0, 1100000));
            default: return ($urandom_range(0, 1) != 0) ? '1 : '0;
        endcase
    endfunction

    // edge of a call; the spoilt position gets a noise edge instead
    task automatic call_edge(input logic r, input logic [PERIOD_BITS-1:0] p);
        if (call_pos == spoil_at)
            send_edge(1'($urandom_range(0, 1)), pick_noise());
        else
            send_edge(r, p);
        call_pos++;
    endtask

    // one call: falling lead-in edge, reset pair, flats, end gap, ring tracking, then a way out
    task automatic send_call(input int flats, input bit broken);
        int  rings;
        int  i;
        int  j;
        int  way_out;
        logic r;
        calls_sent++;
        call_pos = 0;
        spoil_at = broken ? $urandom_range(0, 2 * flats + 4) : -1;
        call_edge(1'b0, pick_noise());
        call_edge(1'b1, pick_in(RST_PULSE_LO, RST_PULSE_HI));
        call_edge(1'b0, pick_in(RST_GAP_LO, RST_GAP_HI));
        for (i = 0; i < flats; i++)
        begin
            call_edge(1'b1, pick_in(FLAT_LOW_LO, FLAT_LOW_HI));
            if (i < flats - 1)
                call_edge(1'b0, pick_in(FLAT_HIGH_LO, FLAT_HIGH_HI));
        end
        call_edge(1'b0, pick_in(END_GAP_LO, END_GAP_HI));
        rings   = $urandom_range(0, 3);
        way_out = $urandom_range(0, 2);
        for (i = 0; i < rings + ((way_out != 0) ? 1 : 0); i++)
        begin
            // ring start to ring on anything but a rising reset-window edge
            r = 1'($urandom_range(0, 1));
            call_edge(r, r ? PERIOD_BITS'($urandom_range(0, int'(RST_PULSE_LO)))
                           : PERIOD_BITS'($urandom_range(0, 1000000)));
            for (j = $urandom_range(0, 2); j > 0; j--)
                call_edge(1'($urandom_range(0, 1)),
                          PERIOD_BITS'($urandom_range(0, int'(RING_EDGE_MIN))));
            if (i < rings)
                call_edge(1'b0, PERIOD_BITS'($urandom_range(int'(RING_EDGE_MIN) + 1,
                                                             int'(RING_RESTART))));
        end
        case (way_out)
            0: call_edge(1'b1, pick_in(RST_PULSE_LO, RST_PULSE_HI));
            1: call_edge(1'b1, PERIOD_BITS'($urandom_range(int'(RING_EDGE_MIN) + 1,
                                                          16777215)));
            default: call_edge(1'b0, PERIOD_BITS'($urandom_range(int'(RING_RESTART) + 1,
                                                                16777215)));
        endcase
    endtask

    // hand-picked edges: window bounds, ring thresholds, period extremes
    task automatic test_directed_windows();
        send_edge(1'b0, '1);
        send_edge(1'b1, PERIOD_BITS'(RST_PULSE_LO + 1));
        send_edge(1'b0, PERIOD_BITS'(RST_GAP_HI - 1));
        send_edge(1'b1, PERIOD_BITS'(FLAT_LOW_LO + 1));
        send_edge(1'b0, PERIOD_BITS'(FLAT_HIGH_LO + 1));
        send_edge(1'b1, PERIOD_BITS'(FLAT_LOW_HI - 1));
        send_edge(1'b0, PERIOD_BITS'(FLAT_HIGH_HI - 1));
        send_edge(1'b1, PERIOD_BITS'(16));
        send_edge(1'b0, PERIOD_BITS'(END_GAP_HI - 1));
        send_edge(1'b0, PERIOD_BITS'(60000));
        send_edge(1'b0, RING_EDGE_MIN);
        send_edge(1'b1, RING_EDGE_MIN);
        send_edge(1'b0, PERIOD_BITS'(RING_EDGE_MIN + 1));
        send_edge(1'b1, PERIOD_BITS'(RST_PULSE_HI - 1));
        send_edge(1'b0, '0);
        send_edge(1'b1, RST_PULSE_HI);
        send_edge(1'b1, '0);
        send_edge(1'b0, FLAT_LOW_LO);
        send_edge(1'b1, RST_PULSE_LO);
        wait_results_done();
    endtask

    // short call with the announcement off, then a ring restart
    task automatic test_announce_off();
        write_announce(1'b0);
        send_edge(1'b0, PERIOD_BITS'(1234));
        send_edge(1'b1, PERIOD_BITS'(300000));
        send_edge(1'b0, PERIOD_BITS'(200000));
        send_edge(1'b1, PERIOD_BITS'(20));
        send_edge(1'b0, PERIOD_BITS'(END_GAP_LO + 1));
        send_edge(1'b0, PERIOD_BITS'(1000));
        send_edge(1'b0, PERIOD_BITS'(RING_RESTART + 1));
        send_edge(1'b1, PERIOD_BITS'(12345));
        wait_results_done();
    endtask

    // flat run long enough to wrap the counter through zero
    task automatic test_count_wrap();
        write_announce(1'b1);
        send_call(258, 1'b0);
        wait_results_done();
    endtask

    // random calls, broken calls and noise bursts
    task automatic test_random_traffic(input int n_items, input logic en);
        int start;
        int k;
        int flats;
        write_announce(en);
        start = edges_sent;
        while (edges_sent - start < n_items)
        begin
            if ($urandom_range(0, 9) == 0)
                pace_on = !pace_on;
            if ($urandom_range(0, 19) == 0)
                wait_results_done();
            if ($urandom_range(0, 4) == 0)
            begin
                for (k = $urandom_range(1, 5); k > 0; k--)
                    send_edge(1'($urandom_range(0, 1)), pick_noise());
            end
            else
            begin
                case ($urandom_range(0, 9))
                    0: flats = 0;
                    1: flats = $urandom_range(11, 40);
                    default: flats = $urandom_range(1, 10);
                endcase
                send_call(flats, $urandom_range(0, 3) == 0);
            end
        end
        pace_on = 1'b1;
        wait_results_done();
    endtask

    // main sequence
    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        write_announce(1'b1);
        test_directed_windows();
        test_announce_off();
        test_count_wrap();
        test_random_traffic(150, 1'b1);
        test_random_traffic(150, 1'b0);
        test_random_traffic(150, 1'b1);
        test_random_traffic(150, 1'b0);
        wait_results_done();
        repeat (60) @(posedge clk);
        $display("run: %0d edge transactions in %0d calls, %0d results checked, %0d announced",
                 edges_sent, calls_sent, results_seen, announce_seen);
        $display("run: window bounds, ring paths, announce on/off, flat count wrap, noise");
        if (err_cnt == 0 && pending_results.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

### filelist.f
hw/rtl/ptcd_pkg.sv
hw/rtl/ptcd_divider.sv
hw/rtl/ptcd_decoder.sv
hw/rtl/pulse_timing_call_decoder_unit.sv
bench/tb.sv
